// ----- design/ghd_pkg.sv -----
// Shared types, constants and tap folding for the Gaussian half downsampler.
`default_nettype none

package ghd_pkg;

   localparam int MAX_WIDTH_DEFAULT    = 1024;
   localparam int CHANNEL_BITS_DEFAULT = 16;
   localparam int CHANNELS             = 4;
   localparam int TAPS                 = 5;
   localparam int LINES                = 4;
   localparam int WIDTH_CFG_BITS       = 11;
   localparam int HEIGHT_CFG_BITS      = 13;
   localparam int ROW_BITS             = 12;
   localparam int HEIGHT_LIMIT         = 4096;
   localparam int WIDTH_RESET          = 1024;
   localparam int HEIGHT_RESET         = 1024;
   localparam int CSR_INDEX_BITS       = 1;
   localparam int CSR_DATA_BITS        = 13;
   localparam int OUT_BITS             = 16;
   localparam int WEIGHT_BITS          = 5;
   localparam int ROUND_BIAS           = 200;
   localparam int SUM_SHIFT            = 4;
   localparam int RECIP_BITS           = 28;
   localparam int RECIP_SHIFT          = 32;
   // ceil(2^32 / 25): exact quotient for every dividend below 2^21
   localparam logic [RECIP_BITS-1:0] RECIP_25 = 28'd171798692;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // weight [j] applies to the sample j positions back from the newest one
   typedef logic [TAPS-1:0][WEIGHT_BITS-1:0] weight_set_type;

   typedef struct packed {
      logic           have_y;
      logic           have_x;
      weight_set_type vw;
      weight_set_type hw;
      logic [1:0]     row_slot;
      logic           row_end;
      logic           frame_end;
   } scan_info_type;

   typedef struct packed {
      logic           valid;
      weight_set_type hw;
      logic           row_end;
      logic           frame_end;
   } reduce_ctl_type;

   // Fold the 1,5,8,5,1 taps onto offsets back from the completing sample.
   // odd: the completing position is the last one of an even-length axis.
   // near_edge: position one or two, where the low edge clamps.
   function automatic weight_set_type fold_weights(input logic odd, input logic near_edge);
      weight_set_type w;
      unique case ({odd, near_edge})
         2'b00: w = {5'd1, 5'd5, 5'd8,  5'd5,  5'd1};
         2'b01: w = {5'd0, 5'd0, 5'd14, 5'd5,  5'd1};
         2'b10: w = {5'd0, 5'd1, 5'd5,  5'd8,  5'd6};
         2'b11: w = {5'd0, 5'd0, 5'd0,  5'd14, 5'd6};
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- design/gaussian_half_downsample.sv -----
// Top level: four-channel 5x5 Gaussian reduce to half size on each axis.
//
// Usage:
//   Source pixels enter in raster order on the req_ channel, one word per
//   accepted cycle (req_valid high, req_stall low). Only the low CHANNEL_BITS
//   bits of each channel are used. Filtered pixels of the half-size image leave
//   on the rsp_ channel with rsp_row_end / rsp_frame_end marking the last
//   pixel of an output row and of the output image.
//   Image size is set through csr_ (index 0 width, index 1 height) while the
//   block is idle; reset leaves 1024 x 1024.
// Throughput: one source pixel per cycle while rsp_stall is low. The line store
//   is one RAM word per column holding four rows; each pixel reads its column
//   and s1 writes it back, with a bypass when the same column returns.
// Pipeline: word (x,y) is completed by pixel (min(W-1,2x+2), min(H-1,2y+2))
//   and passes the s1, window, s3 and output registers before it reaches rsp_.
// Reset: clears counters, pipeline valids and the output buffer; the line
//   store is not cleared, since every row is written before it is read.
// Stall: rsp_ words hold while rsp_stall is high; one extra word is caught in
//   a skid register, after which req_stall rises until the skid drains.
`default_nettype none

module gaussian_half_downsample #(
   parameter int MAX_WIDTH    = ghd_pkg::MAX_WIDTH_DEFAULT,
   parameter int CHANNEL_BITS = ghd_pkg::CHANNEL_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [ghd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ghd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [15:0]                         req_chan_r,
   input  wire logic [15:0]                         req_chan_g,
   input  wire logic [15:0]                         req_chan_b,
   input  wire logic [15:0]                         req_chan_a,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ghd_pkg::OUT_BITS-1:0]             rsp_out_r,
   output logic [ghd_pkg::OUT_BITS-1:0]             rsp_out_g,
   output logic [ghd_pkg::OUT_BITS-1:0]             rsp_out_b,
   output logic [ghd_pkg::OUT_BITS-1:0]             rsp_out_a,
   output logic                                     rsp_row_end,
   output logic                                     rsp_frame_end
);

   import ghd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic                                          en, acc;
   logic [CW-1:0]                                 col;
   scan_info_type                                 info;
   logic [CHANNELS-1:0][CHANNEL_BITS-1:0]         pix;
   logic [TAPS-1:0][CHANNELS-1:0][CHANNEL_BITS+4:0] win;
   reduce_ctl_type                                ctl;
   logic [CHANNELS-1:0][OUT_BITS-1:0]             rsp_data;

   // the pipeline moves whenever the skid register is empty
   assign req_stall = !en;
   assign acc       = req_valid && en;

   // drop the unused high bits of each channel
   assign pix[0] = req_chan_r[CHANNEL_BITS-1:0];
   assign pix[1] = req_chan_g[CHANNEL_BITS-1:0];
   assign pix[2] = req_chan_b[CHANNEL_BITS-1:0];
   assign pix[3] = req_chan_a[CHANNEL_BITS-1:0];

   ghd_scan #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .acc      (acc),
      .col      (col),
      .info     (info)
   );

   ghd_column #(
      .MAX_WIDTH   (MAX_WIDTH),
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_column (
      .clock(clock),
      .reset(reset),
      .en   (en),
      .acc  (acc),
      .col  (col),
      .info (info),
      .pix  (pix),
      .win  (win),
      .ctl  (ctl)
   );

   ghd_reduce #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_reduce (
      .clock        (clock),
      .reset        (reset),
      .win          (win),
      .ctl          (ctl),
      .rsp_stall    (rsp_stall),
      .en           (en),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_row_end  (rsp_row_end),
      .rsp_frame_end(rsp_frame_end)
   );

   assign rsp_out_r = rsp_data[0];
   assign rsp_out_g = rsp_data[1];
   assign rsp_out_b = rsp_data[2];
   assign rsp_out_a = rsp_data[3];

endmodule

`default_nettype wire

// ----- design/ghd_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module ghd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/ghd_scan.sv -----
// Size registers, raster position counters and per-pixel tap decode.
`default_nettype none

module ghd_scan #(
   parameter int MAX_WIDTH = ghd_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [ghd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ghd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic                                acc,
   output logic      [$clog2(MAX_WIDTH)-1:0]        col,
   output ghd_pkg::scan_info_type                   info
);

   import ghd_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (CW + 1 > WIDTH_CFG_BITS) ? CW + 1 : WIDTH_CFG_BITS;

   logic [WIDTH_CFG_BITS-1:0]  image_width_ff, image_width_in;
   logic [HEIGHT_CFG_BITS-1:0] image_height_ff, image_height_in;
   logic [CW-1:0]              col_cnt_ff, col_cnt_in;
   logic [ROW_BITS-1:0]        row_cnt_ff, row_cnt_in;

   logic [CMPW-1:0]            width_raw, wlim, col_ext, col_inc;
   logic [HEIGHT_CFG_BITS-1:0] h_lim, row_step, row_inc;
   logic [ROW_BITS-1:0]        row, yc;
   logic [CW-1:0]              xc;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  image_width_in  = csr_wdata[WIDTH_CFG_BITS-1:0];
            CSR_IMAGE_HEIGHT: image_height_in = csr_wdata;
            default:          image_width_in  = image_width_ff;
         endcase
      end
   end

   // clamp the sizes to what the line store and row counter hold
   always_comb begin
      width_raw = CMPW'(image_width_ff);
      if (width_raw == '0) begin
         wlim = CMPW'(1);
      end else if (width_raw > CMPW'(MAX_WIDTH)) begin
         wlim = CMPW'(MAX_WIDTH);
      end else begin
         wlim = width_raw;
      end
      if (image_height_ff == '0) begin
         h_lim = HEIGHT_CFG_BITS'(1);
      end else if (image_height_ff > HEIGHT_CFG_BITS'(HEIGHT_LIMIT)) begin
         h_lim = HEIGHT_CFG_BITS'(HEIGHT_LIMIT);
      end else begin
         h_lim = image_height_ff;
      end
   end

   // wrap a stale position after a size change, then advance
   always_comb begin
      col      = col_cnt_ff;
      row_step = {1'b0, row_cnt_ff};
      if (CMPW'(col_cnt_ff) >= wlim) begin
         col      = '0;
         row_step = row_step + 1'b1;
      end
      if (row_step >= h_lim) begin
         row_step = '0;
      end
      row     = row_step[ROW_BITS-1:0];
      col_ext = CMPW'(col);
      col_inc = col_ext + 1'b1;
      row_inc = {1'b0, row} + 1'b1;

      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (acc) begin
         if (col_inc >= wlim) begin
            col_cnt_in = '0;
            row_cnt_in = (row_inc >= h_lim) ? '0 : row_inc[ROW_BITS-1:0];
         end else begin
            col_cnt_in = col_inc[CW-1:0];
            row_cnt_in = row;
         end
      end
   end

   always_comb begin
      yc = (row >> 1) - ROW_BITS'(!row[0]);
      xc = (col >> 1) - CW'(!col[0]);

      info.have_y    = (!row[0] && row >= ROW_BITS'(2)) ||
                       (!h_lim[0] && {1'b0, row} == h_lim - 1'b1);
      info.have_x    = (!col[0] && col_ext >= CMPW'(2)) ||
                       (!wlim[0] && col_ext == wlim - 1'b1);
      info.vw        = fold_weights(row[0], row == ROW_BITS'(1) || row == ROW_BITS'(2));
      info.hw        = fold_weights(col[0], col_ext == CMPW'(1) || col_ext == CMPW'(2));
      info.row_slot  = row[1:0];
      info.row_end   = CMPW'(xc) == (wlim >> 1) - 1'b1;
      info.frame_end = info.row_end && ({1'b0, yc} == (h_lim >> 1) - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_CFG_BITS'(WIDTH_RESET);
         image_height_ff <= HEIGHT_CFG_BITS'(HEIGHT_RESET);
         col_cnt_ff      <= '0;
         row_cnt_ff      <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         col_cnt_ff      <= col_cnt_in;
         row_cnt_ff      <= row_cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/ghd_column.sv -----
// Line store read-modify-write, vertical column sums and horizontal window.
`default_nettype none

module ghd_column #(
   parameter int MAX_WIDTH    = ghd_pkg::MAX_WIDTH_DEFAULT,
   parameter int CHANNEL_BITS = ghd_pkg::CHANNEL_BITS_DEFAULT
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          en,
   input  wire logic                                          acc,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]                  col,
   input  wire ghd_pkg::scan_info_type                        info,
   input  wire logic [ghd_pkg::CHANNELS-1:0][CHANNEL_BITS-1:0] pix,
   output logic [ghd_pkg::TAPS-1:0][ghd_pkg::CHANNELS-1:0][CHANNEL_BITS+4:0] win,
   output ghd_pkg::reduce_ctl_type                            ctl
);

   import ghd_pkg::*;

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int SW     = CHANNEL_BITS + 5;
   localparam int WORD_W = LINES * CHANNELS * CHANNEL_BITS;

   logic                                           s1_valid_ff, s1_valid_in;
   logic [CW-1:0]                                  s1_col_ff;
   scan_info_type                                  s1_info_ff;
   logic [CHANNELS-1:0][CHANNEL_BITS-1:0]          s1_pix_ff;
   logic                                           fwd_ff, fwd_in;
   logic [LINES-1:0][CHANNELS-1:0][CHANNEL_BITS-1:0] fwd_word_ff;
   logic [WORD_W-1:0]                              rd_data;
   logic [LINES-1:0][CHANNELS-1:0][CHANNEL_BITS-1:0] line_word, merged;
   logic [CHANNELS-1:0][SW-1:0]                    colsum;
   logic [TAPS-1:0][CHANNELS-1:0][SW-1:0]          win_ff, win_in;
   reduce_ctl_type                                 ctl_ff, ctl_in;

   ghd_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (en && s1_valid_ff),
      .wr_addr(s1_col_ff),
      .wr_data(merged),
      .rd_en  (acc),
      .rd_addr(col),
      .rd_data(rd_data)
   );

   // the RAM returns the old word when the next pixel reads the column just written
   assign line_word = fwd_ff ? fwd_word_ff : rd_data;

   always_comb begin
      merged                      = line_word;
      merged[s1_info_ff.row_slot] = s1_pix_ff;
   end

   // rows with zero weight may not be written yet, so skip them
   always_comb begin
      logic [1:0] slot;
      for (int c = 0; c < CHANNELS; c++) begin
         colsum[c] = SW'(s1_info_ff.vw[0]) * SW'(s1_pix_ff[c]);
         for (int j = 1; j < TAPS; j++) begin
            slot = s1_info_ff.row_slot - 2'(j);
            if (s1_info_ff.vw[j] != '0) begin
               colsum[c] = colsum[c] + SW'(s1_info_ff.vw[j]) * SW'(line_word[slot][c]);
            end
         end
      end
   end

   always_comb begin
      win_in = win_ff;
      if (en && s1_valid_ff && s1_info_ff.have_y) begin
         for (int j = 0; j < TAPS - 1; j++) begin
            win_in[j] = win_ff[j + 1];
         end
         win_in[TAPS-1] = colsum;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      fwd_in      = fwd_ff;
      ctl_in      = ctl_ff;
      if (en) begin
         s1_valid_in      = acc;
         fwd_in           = s1_valid_ff && acc && (s1_col_ff == col);
         ctl_in.valid     = s1_valid_ff && s1_info_ff.have_y && s1_info_ff.have_x;
         ctl_in.hw        = s1_info_ff.hw;
         ctl_in.row_end   = s1_info_ff.row_end;
         ctl_in.frame_end = s1_info_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         ctl_ff      <= '0;
         win_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_ff      <= fwd_in;
         ctl_ff      <= ctl_in;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_col_ff   <= col;
         s1_info_ff  <= info;
         s1_pix_ff   <= pix;
         fwd_word_ff <= merged;
      end
   end

   assign win = win_ff;
   assign ctl = ctl_ff;

endmodule

`default_nettype wire

// ----- design/ghd_reduce.sv -----
// Horizontal weighted sum, divide by 400 and output skid buffer.
`default_nettype none

module ghd_reduce #(
   parameter int CHANNEL_BITS = ghd_pkg::CHANNEL_BITS_DEFAULT
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic [ghd_pkg::TAPS-1:0][ghd_pkg::CHANNELS-1:0][CHANNEL_BITS+4:0] win,
   input  wire ghd_pkg::reduce_ctl_type                       ctl,
   input  wire logic                                          rsp_stall,
   output logic                                               en,
   output logic                                               rsp_valid,
   output logic [ghd_pkg::CHANNELS-1:0][ghd_pkg::OUT_BITS-1:0] rsp_data,
   output logic                                               rsp_row_end,
   output logic                                               rsp_frame_end
);

   import ghd_pkg::*;

   localparam int XW = CHANNEL_BITS + 5;
   localparam int TW = CHANNEL_BITS + 9;
   localparam int PW = XW + RECIP_BITS;

   logic [CHANNELS-1:0][XW-1:0]           x_val;
   logic                                  s3_valid_ff, s3_valid_in;
   logic [CHANNELS-1:0][XW-1:0]           s3_x_ff;
   logic                                  s3_re_ff, s3_fe_ff;
   logic [CHANNELS-1:0][CHANNEL_BITS-1:0] quot;

   logic                                  out_valid_ff, out_valid_in;
   logic [CHANNELS-1:0][CHANNEL_BITS-1:0] out_data_ff, out_data_in;
   logic                                  out_re_ff, out_re_in, out_fe_ff, out_fe_in;
   logic                                  skid_valid_ff, skid_valid_in;
   logic [CHANNELS-1:0][CHANNEL_BITS-1:0] skid_data_ff, skid_data_in;
   logic                                  skid_re_ff, skid_re_in, skid_fe_ff, skid_fe_in;
   logic                                  take;

   // total plus half the weight sum, then drop the factor of 16 in 400
   always_comb begin
      logic [TW-1:0] t;
      for (int c = 0; c < CHANNELS; c++) begin
         t = TW'(ROUND_BIAS);
         for (int j = 0; j < TAPS; j++) begin
            t = t + TW'(ctl.hw[j]) * TW'(win[TAPS-1-j][c]);
         end
         x_val[c] = t[TW-1:SUM_SHIFT];
      end
   end

   // divide by 25 through the reciprocal
   always_comb begin
      logic [PW-1:0] prod;
      for (int c = 0; c < CHANNELS; c++) begin
         prod    = PW'(s3_x_ff[c]) * PW'(RECIP_25);
         quot[c] = prod[RECIP_SHIFT +: CHANNEL_BITS];
      end
   end

   assign en   = !skid_valid_ff;
   assign take = out_valid_ff && !rsp_stall;

   always_comb begin
      s3_valid_in   = en ? ctl.valid : s3_valid_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_re_in     = out_re_ff;
      out_fe_in     = out_fe_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_re_in    = skid_re_ff;
      skid_fe_in    = skid_fe_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            out_re_in     = skid_re_ff;
            out_fe_in     = skid_fe_ff;
            skid_valid_in = 1'b0;
         end
      end else if (s3_valid_ff) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = quot;
            out_re_in    = s3_re_ff;
            out_fe_in    = s3_fe_ff;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = quot;
            skid_re_in    = s3_re_ff;
            skid_fe_in    = s3_fe_ff;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff   <= s3_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_x_ff  <= x_val;
         s3_re_ff <= ctl.row_end;
         s3_fe_ff <= ctl.frame_end;
      end
      out_data_ff  <= out_data_in;
      out_re_ff    <= out_re_in;
      out_fe_ff    <= out_fe_in;
      skid_data_ff <= skid_data_in;
      skid_re_ff   <= skid_re_in;
      skid_fe_ff   <= skid_fe_in;
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         rsp_data[c] = OUT_BITS'(out_data_ff[c]);
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_row_end   = out_re_ff;
   assign rsp_frame_end = out_fe_ff;

endmodule

`default_nettype wire

// ----- design/ghd_checker.sv -----
// Port-level checker for the Gaussian half downsampler, bound to the top level.
`default_nettype none

module ghd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_out_r,
   input wire logic [15:0] rsp_out_a,
   input wire logic        rsp_row_end,
   input wire logic        rsp_frame_end
);

   // the last pixel of the image also ends its row
   a_frame_end_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_frame_end || rsp_row_end))
      else $error("frame end without row end");

   // reset empties the output side
   a_reset_no_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word after reset");

   // reset empties the skid register, so input is open right after
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result word dropped under stall");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_out_r) && $stable(rsp_out_a) &&
                                    $stable(rsp_row_end) && $stable(rsp_frame_end)))
      else $error("result word changed under stall");

endmodule

bind gaussian_half_downsample ghd_checker u_ghd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_r    (rsp_out_r),
   .rsp_out_a    (rsp_out_a),
   .rsp_row_end  (rsp_row_end),
   .rsp_frame_end(rsp_frame_end)
);

`default_nettype wire
